>>> rtl/kim_pkg.sv
// ----------------------------------------------------------------------------
// kim_pkg: shared constants for the key to row index map
// Sizes of the row and bucket tables, the hash split and the status codes.
// ----------------------------------------------------------------------------
package kim_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int BUCKETS  = 2048;

  localparam int KEY_W  = 64;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int SLOT_W = $clog2(BUCKETS);
  localparam int CAP_W  = 11;

  // Only the low bits of the product feed the folded bucket slot.
  localparam int HASH_W = 32 + SLOT_W;
  localparam int LO_W   = (HASH_W + 1) / 2;
  localparam int HI_W   = HASH_W - LO_W;

  localparam logic [KEY_W-1:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_ROWS);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

endpackage

>>> rtl/kim_ram.sv
// ----------------------------------------------------------------------------
// kim_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module kim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kim_hash.sv
// ----------------------------------------------------------------------------
// kim_hash: multiplicative bucket hash
// Forms the low product bits of key times the hash constant from three
// partial products on one shared multiplier, then folds them to a slot.
// ----------------------------------------------------------------------------
module kim_hash
  import kim_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [SLOT_W-1:0] slot
);

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_HL = 2'd1;
  localparam logic [1:0] STEP_LH = 2'd2;

  localparam logic [LO_W-1:0] C_LO = HASH_MUL[LO_W-1:0];
  localparam logic [LO_W-1:0] C_HI = LO_W'(HASH_MUL[HASH_W-1:LO_W]);

  logic                run;
  logic [1:0]          step;
  logic [HASH_W-1:0]   acc;
  logic [LO_W-1:0]     mul_a;
  logic [LO_W-1:0]     mul_c;
  logic [2*LO_W-1:0]   prod;
  logic [HASH_W-1:0]   term;
  logic [HASH_W-1:0]   acc_next;

  always_comb begin
    mul_a = key[LO_W-1:0];
    mul_c = C_LO;
    case (step)
      STEP_HL: mul_a = LO_W'(key[HASH_W-1:LO_W]);
      STEP_LH: mul_c = C_HI;
      default: ;
    endcase
  end

  assign prod = mul_a * mul_c;

  always_comb begin
    if (step == STEP_LL) begin
      term     = prod[HASH_W-1:0];
      acc_next = term;
    end else begin
      term     = {prod[HI_W-1:0], {LO_W{1'b0}}};
      acc_next = acc + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= STEP_LL;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= STEP_LL;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == STEP_LH) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      acc <= acc_next;
    end
  end

  assign slot = acc[SLOT_W-1:0] ^ acc[32 +: SLOT_W];

endmodule

>>> rtl/key_to_row_index_map_autogrow.sv
// ----------------------------------------------------------------------------
// key_to_row_index_map_autogrow: sparse 64-bit key to dense row index map
// A hashed bucket RAM with linear probing points into a key RAM; unknown keys
// are appended at the next free row when growing is allowed.
// ----------------------------------------------------------------------------
// After reset the bucket RAM is cleared one entry a cycle with busy high; the
// capacity register can be written throughout.
// A beat passes through S_HASH, then per probe S_BREQ and S_BCHK, plus S_KCHK
// when the bucket is occupied, and ends in S_DECIDE, which sets the result strobe.
// The next start beat is taken in the cycle the result strobe is high.
// A probe of a filled bucket costs a bucket RAM read, then a key RAM read.
// ----------------------------------------------------------------------------
module key_to_row_index_map_autogrow
  import kim_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [KEY_W-1:0] key,
  input  logic                    auto_grow,
  input  logic                    lookup_only,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_data,
  output logic                    done,
  output logic [ROW_W-1:0]        row_index,
  output logic                    found,
  output logic                    inserted,
  output logic [1:0]              status
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_BREQ   = 3'd3;
  localparam logic [2:0] S_BCHK   = 3'd4;
  localparam logic [2:0] S_KCHK   = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BUCKETS - 1);

  logic [2:0]        state;
  logic [SLOT_W-1:0] clr_addr;
  logic [KEY_W-1:0]  key_q;
  logic              grow_q;
  logic              look_q;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] probe_n;
  logic [ROW_W-1:0]  row_q;
  logic              hit;
  logic              has_empty;
  logic [CNT_W-1:0]  row_count;
  logic [CAP_W-1:0]  capacity;
  logic [CAP_W-1:0]  limit;

  logic              accept;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_slot;
  logic              do_insert;
  logic              last_probe;

  logic              bkt_we;
  logic [SLOT_W-1:0] bkt_waddr;
  logic [CNT_W-1:0]  bkt_wdata;
  logic [CNT_W-1:0]  bkt_rdata;
  logic [ROW_W-1:0]  bkt_row;
  logic              key_we;
  logic [KEY_W-1:0]  key_rdata;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign limit      = (capacity < CAP_MAX) ? capacity : CAP_MAX;
  assign last_probe = (probe_n == LAST_SLOT);
  assign bkt_row    = ROW_W'(bkt_rdata - CNT_W'(1));

  assign do_insert = (state == S_DECIDE) && !hit && !look_q && grow_q &&
                     has_empty && (CAP_W'(row_count) < limit);

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = slot;
    bkt_wdata = CNT_W'(row_count + CNT_W'(1));
    if (state == S_CLEAR) begin
      bkt_we    = 1'b1;
      bkt_waddr = clr_addr;
      bkt_wdata = '0;
    end else if (do_insert) begin
      bkt_we = 1'b1;
    end
  end

  assign key_we = do_insert;

  kim_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (key_q),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  kim_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (slot),
    .rdata (bkt_rdata)
  );

  kim_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ROWS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (row_count[ROW_W-1:0]),
    .wdata (key_q),
    .raddr (bkt_row),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      row_count <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_BREQ;
          end
        end
        S_BREQ: begin
          state <= S_BCHK;
        end
        S_BCHK: begin
          if (bkt_rdata == '0) begin
            state <= S_DECIDE;
          end else if (bkt_rdata <= row_count) begin
            state <= S_KCHK;
          end else if (last_probe) begin
            state <= S_DECIDE;
          end else begin
            state <= S_BREQ;
          end
        end
        S_KCHK: begin
          if (key_rdata == key_q || last_probe) begin
            state <= S_DECIDE;
          end else begin
            state <= S_BREQ;
          end
        end
        S_DECIDE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (do_insert) begin
            row_count <= row_count + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        key_q  <= $unsigned(key);
        grow_q <= auto_grow;
        look_q <= lookup_only;
      end
      S_HASH: begin
        slot      <= hash_slot;
        probe_n   <= '0;
        hit       <= 1'b0;
        has_empty <= 1'b0;
      end
      S_BCHK: begin
        if (bkt_rdata == '0) begin
          has_empty <= 1'b1;
        end else if (bkt_rdata <= row_count) begin
          row_q <= bkt_row;
        end else begin
          slot    <= slot + SLOT_W'(1);
          probe_n <= probe_n + SLOT_W'(1);
        end
      end
      S_KCHK: begin
        if (key_rdata == key_q) begin
          hit <= 1'b1;
        end else begin
          slot    <= slot + SLOT_W'(1);
          probe_n <= probe_n + SLOT_W'(1);
        end
      end
      S_DECIDE: begin
        row_index <= '0;
        found     <= 1'b0;
        inserted  <= 1'b0;
        status    <= ST_OK;
        if (hit) begin
          row_index <= row_q;
          found     <= 1'b1;
        end else if (look_q) begin
          status <= ST_OK;
        end else if (!grow_q) begin
          status <= ST_NOT_FOUND;
        end else if (do_insert) begin
          row_index <= row_count[ROW_W-1:0];
          found     <= 1'b1;
          inserted  <= 1'b1;
        end else begin
          status <= ST_FULL;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/kim_checker.sv
// ----------------------------------------------------------------------------
// kim_checker: port-level checks for the key to row index map
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module kim_checker
  import kim_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [ROW_W-1:0] row_index,
  input logic             found,
  input logic             inserted,
  input logic [1:0]       status
);

  // An accepted beat keeps the block busy until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted beat");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_insert_found: assert property (@(posedge clk) disable iff (rst)
    done && inserted |-> found && status == ST_OK)
    else $error("inserted beat without a row index");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == ST_OK)
    else $error("found beat with an error status");

  a_miss_row_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> row_index == '0 && !inserted)
    else $error("miss beat carries a row index");

endmodule

bind key_to_row_index_map_autogrow kim_checker u_kim_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: key to row index map with insert on miss
// A directed table of keys and capacity settings, followed by random beats
// that fill the table to its limit, with every answer compared against a fixed
// expected answer or against a behavioral model of the map.
// ----------------------------------------------------------------------------
module testbench;
  import kim_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic             found;
    logic             inserted;
    logic [1:0]       status;
  } map_answer_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             grow;
    logic             look;
    bit               set_cap;
    logic [CAP_W-1:0] cap;
    bit               typed;
    map_answer_t      answer;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [KEY_W-1:0] key = '0;
  logic                    auto_grow = 1'b0;
  logic                    lookup_only = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CAP_W-1:0]        cfg_data = '0;
  logic                    done;
  logic [ROW_W-1:0]        row_index;
  logic                    found;
  logic                    inserted;
  logic [1:0]              status;

  int                 row_of_key [logic [KEY_W-1:0]];
  logic [KEY_W-1:0]   key_by_row [$];
  int unsigned        rows_used = 0;
  logic [CAP_W-1:0]   capacity_shadow = CAP_RESET;
  map_answer_t        expected_answers [$];
  directed_row_t      directed_rows [$];
  int unsigned        beat_count = 0;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  bit                 no_idle = 1'b0;
  map_answer_t        got_answer;
  map_answer_t        want_answer;

  key_to_row_index_map_autogrow dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .key         (key),
    .auto_grow   (auto_grow),
    .lookup_only (lookup_only),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .row_index   (row_index),
    .found       (found),
    .inserted    (inserted),
    .status      (status)
  );

  always #5 clk = ~clk;

  function automatic map_answer_t answer(input int unsigned row, input logic f,
                                         input logic ins, input logic [1:0] st);
    map_answer_t a;
    a.row_index = ROW_W'(row);
    a.found     = f;
    a.inserted  = ins;
    a.status    = st;
    return a;
  endfunction

  function automatic map_answer_t predict_answer(input logic [KEY_W-1:0] k,
                                                 input logic grow, input logic look);
    map_answer_t a;
    int unsigned lim;
    a = answer(0, 1'b0, 1'b0, ST_OK);
    lim = (capacity_shadow < MAX_ROWS) ? capacity_shadow : MAX_ROWS;
    if (row_of_key.exists(k)) begin
      a = answer(row_of_key[k], 1'b1, 1'b0, ST_OK);
    end else if (!look) begin
      if (!grow) begin
        a.status = ST_NOT_FOUND;
      end else if (rows_used >= lim) begin
        a.status = ST_FULL;
      end else begin
        row_of_key[k] = rows_used;
        key_by_row = {key_by_row, k};
        a = answer(rows_used, 1'b1, 1'b1, ST_OK);
        rows_used++;
      end
    end
    return a;
  endfunction

  task automatic add_key_row(input logic [KEY_W-1:0] k, input logic g, input logic l,
                             input bit typed, input map_answer_t a);
    directed_row_t r;
    r.key = k;
    r.grow = g;
    r.look = l;
    r.set_cap = 1'b0;
    r.cap = '0;
    r.typed = typed;
    r.answer = a;
    directed_rows = {directed_rows, r};
  endtask

  task automatic add_cap_row(input logic [CAP_W-1:0] v);
    directed_row_t r;
    r.key = '0;
    r.grow = 1'b0;
    r.look = 1'b0;
    r.set_cap = 1'b1;
    r.cap = v;
    r.typed = 1'b0;
    r.answer = '0;
    directed_rows = {directed_rows, r};
  endtask

  task automatic issue_beat(input logic [KEY_W-1:0] k, input logic g, input logic l,
                            input bit typed, input map_answer_t typed_answer);
    map_answer_t a;
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    key         <= k;
    auto_grow   <= g;
    lookup_only <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = predict_answer(k, g, l);
    if (typed) begin
      a = typed_answer;
    end
    expected_answers = {expected_answers, a};
    beat_count++;
  endtask

  task automatic random_beat(input int fresh_pct, input int grow_pct, input int look_pct);
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (rows_used > 0 && pick >= fresh_pct) begin
      k = key_by_row[$urandom_range(0, rows_used - 1)];
    end else if ($urandom_range(0, 99) < 4) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = {1'b1, {(KEY_W-1){1'b0}}};
        default: k = {1'b0, {(KEY_W-1){1'b1}}};
      endcase
    end else begin
      k = {$urandom, $urandom};
    end
    no_idle = (beat_count >= 700 && beat_count < 900);
    issue_beat(k, $urandom_range(0, 99) < grow_pct, $urandom_range(0, 99) < look_pct,
               1'b0, '0);
  endtask

  task automatic finish_phase();
    start <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    capacity_shadow = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      got_answer.row_index = row_index;
      got_answer.found     = found;
      got_answer.inserted  = inserted;
      got_answer.status    = status;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result beat row_index=%0d found=%0b inserted=%0b status=%0d",
                 $time, row_index, found, inserted, status);
        error_count++;
      end else begin
        want_answer = expected_answers.pop_front();
        if (got_answer !== want_answer) begin
          $write("%0t: expected row_index=%0d found=%0b inserted=%0b status=%0d, ",
                 $time, want_answer.row_index, want_answer.found, want_answer.inserted,
                 want_answer.status);
          $display("got row_index=%0d found=%0b inserted=%0b status=%0d",
                   got_answer.row_index, got_answer.found, got_answer.inserted,
                   got_answer.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] kmin;
    logic [KEY_W-1:0] kmax;
    kmin = {1'b1, {(KEY_W-1){1'b0}}};
    kmax = {1'b0, {(KEY_W-1){1'b1}}};

    add_key_row('0,   1'b0, 1'b1, 1'b1, answer(0, 1'b0, 1'b0, ST_OK));
    add_key_row('1,   1'b0, 1'b0, 1'b1, answer(0, 1'b0, 1'b0, ST_NOT_FOUND));
    add_key_row(kmax, 1'b1, 1'b1, 1'b1, answer(0, 1'b0, 1'b0, ST_OK));
    add_key_row('0,   1'b1, 1'b0, 1'b1, answer(0, 1'b1, 1'b1, ST_OK));
    add_key_row(kmin, 1'b1, 1'b0, 1'b1, answer(1, 1'b1, 1'b1, ST_OK));
    add_key_row(kmax, 1'b1, 1'b0, 1'b1, answer(2, 1'b1, 1'b1, ST_OK));
    add_key_row('1,   1'b1, 1'b0, 1'b1, answer(3, 1'b1, 1'b1, ST_OK));
    add_key_row('0,   1'b0, 1'b1, 1'b1, answer(0, 1'b1, 1'b0, ST_OK));
    add_key_row(kmin, 1'b0, 1'b0, 1'b1, answer(1, 1'b1, 1'b0, ST_OK));
    add_key_row(kmax, 1'b1, 1'b0, 1'b1, answer(2, 1'b1, 1'b0, ST_OK));
    add_key_row(64'd1, 1'b1, 1'b0, 1'b0, '0);
    add_key_row(64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, '0);
    add_key_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b0, '0);
    add_key_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, '0);
    add_cap_row(CAP_W'(3));
    add_key_row(64'd2, 1'b1, 1'b0, 1'b1, answer(0, 1'b0, 1'b0, ST_FULL));
    add_key_row('1,    1'b1, 1'b1, 1'b0, '0);
    add_key_row(64'd2, 1'b0, 1'b0, 1'b1, answer(0, 1'b0, 1'b0, ST_NOT_FOUND));
    add_cap_row(CAP_W'(7));
    add_key_row(64'd2, 1'b1, 1'b0, 1'b0, '0);
    add_key_row(64'd3, 1'b1, 1'b0, 1'b1, answer(0, 1'b0, 1'b0, ST_FULL));
    add_cap_row(CAP_MAX);
    add_key_row(64'd3, 1'b1, 1'b0, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cap) begin
        finish_phase();
        write_capacity(directed_rows[i].cap);
      end else begin
        issue_beat(directed_rows[i].key, directed_rows[i].grow, directed_rows[i].look,
                   directed_rows[i].typed, directed_rows[i].answer);
      end
    end
    finish_phase();

    // A capacity far below the row count turns every insert into a full answer.
    write_capacity(CAP_W'(1));
    repeat (40) random_beat(50, 80, 20);
    finish_phase();

    write_capacity(CAP_W'(rows_used + $urandom_range(5, 40)));
    repeat (100) random_beat(55, 75, 20);
    finish_phase();

    // Out-of-range capacity: the table fills up to its row limit.
    write_capacity('1);
    while (rows_used < MAX_ROWS) random_beat(97, 99, 1);
    repeat (60) random_beat(50, 80, 20);
    finish_phase();

    write_capacity(CAP_MAX);
    repeat (30) random_beat(50, 80, 20);
    finish_phase();

    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
